/* rtl/mks_pkg.sv */
// Package for the 8x8 matrix keypad scanner: widths, result type, key decode.
// Depends on nothing; imported by mks_core, matrix_keypad_scanner_8x8 and mks_checker.
`default_nettype none

package mks_pkg;

    localparam int unsigned SENSE_W = 8;
    localparam int unsigned COL_W   = 3;
    localparam int unsigned KEY_W   = 7;
    localparam int unsigned TICK_W  = 16;

    localparam logic [TICK_W-1:0]  DEBOUNCE_RESET = 16'd15;
    localparam logic [SENSE_W-1:0] ALL_RELEASED   = 8'hFF;
    localparam logic [COL_W-1:0]   LAST_COLUMN    = 3'd7;

    // Result beat of one scan tick
    typedef struct packed {
        logic [COL_W-1:0] drive_column;
        logic [KEY_W-1:0] key_code;
        logic             scan_done;
    } mks_result_t;

    // Code offset of each column
    function automatic logic [KEY_W-1:0] column_base(input logic [COL_W-1:0] col);
        logic [KEY_W-1:0] base;
        case (col)
            3'd0:    base = 7'd8;
            3'd1:    base = 7'd0;
            3'd2:    base = 7'd24;
            3'd3:    base = 7'd16;
            3'd4:    base = 7'd40;
            3'd5:    base = 7'd32;
            3'd6:    base = 7'd56;
            3'd7:    base = 7'd48;
            default: base = 7'd0;
        endcase
        return base;
    endfunction

    // Exactly one low line gives base + (line ^ 1) + 1, anything else gives 0
    function automatic logic [KEY_W-1:0] decode_key(input logic [COL_W-1:0]   col,
                                                    input logic [SENSE_W-1:0] sense);
        logic [SENSE_W-1:0] low;
        logic [COL_W-1:0]   line;
        logic               single;
        low    = ~sense;
        single = (low != '0) && ((low & (low - 8'd1)) == '0);
        line   = '0;
        for (int i = 0; i < SENSE_W; i++) begin
            if (low[i]) begin
                line = COL_W'(i);
            end
        end
        if (single) begin
            return column_base(col) + KEY_W'(line ^ 3'd1) + 7'd1;
        end
        return '0;
    endfunction

endpackage

`default_nettype wire

/* rtl/mks_core.sv */
// Scan state and per-tick update: column walk, debounce wait, held key code.
// Depends on mks_pkg.
`default_nettype none

module mks_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        step_en,
    input  wire logic [mks_pkg::SENSE_W-1:0] sense,
    input  wire logic [mks_pkg::TICK_W-1:0]  debounce_ticks,
    output mks_pkg::mks_result_t             result
);
    import mks_pkg::*;

    logic [COL_W-1:0]  column_reg, column_next;
    logic              active_reg, active_next;
    logic [TICK_W-1:0] count_reg, count_next;
    logic [KEY_W-1:0]  held_reg, held_next;

    logic              advance;
    logic [KEY_W-1:0]  held_mid;

    // Next-state logic for one tick
    always_comb
    begin
        column_next = column_reg;
        active_next = active_reg;
        count_next  = count_reg;
        held_mid    = held_reg;
        advance     = 1'b0;
        result      = '0;

        if (active_reg) begin
            if (count_reg != '0) begin
                count_next = count_reg - 16'd1;
            end else begin
                active_next = 1'b0;
                if (sense != ALL_RELEASED) begin
                    held_mid = decode_key(column_reg, sense);
                end
                advance = 1'b1;
            end
        end else if (sense != ALL_RELEASED) begin
            active_next = 1'b1;
            count_next  = debounce_ticks;
        end else begin
            advance = 1'b1;
        end

        held_next = held_mid;
        if (advance) begin
            if (column_reg == LAST_COLUMN) begin
                result.key_code  = held_mid;
                result.scan_done = 1'b1;
                held_next        = '0;
                column_next      = '0;
            end else begin
                column_next = column_reg + 3'd1;
            end
        end
        result.drive_column = column_next;
    end

    // State registers, updated once per tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            column_reg <= '0;
            active_reg <= 1'b0;
            count_reg  <= '0;
            held_reg   <= '0;
        end else if (step_en) begin
            column_reg <= column_next;
            active_reg <= active_next;
            count_reg  <= count_next;
            held_reg   <= held_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/matrix_keypad_scanner_8x8.sv */
// 8x8 matrix keypad scanner with debounce.
//
// Input channel (in_valid / in_stall, sense_lines): one beat per scan tick,
// the eight sense lines sampled while column drive_column of the previous
// result is held low (column 0 after reset). A low bit means pressed.
// Output channel (out_valid / out_stall): one result beat per input beat,
// in order: drive_column for the next sample, and on the tick that ends a
// full scan of columns 0..7, scan_done with key_code (0 for none/invalid).
// Config channel (cfg_valid / cfg_ready, cfg_data): debounce_ticks, the
// ticks waited between the detecting and the confirming sample. cfg_ready
// is always high; write only while the block is idle.
// Throughput: one beat per cycle while the receiver does not stall; an
// input register and a result register hold one beat each, and the scan
// update sits between them. When the receiver stalls, the result holds and
// at most one more input beat is taken before in_stall rises. Reset clears
// the scan to column 0, drops both registers and sets debounce_ticks to 15.
// Depends on mks_pkg and mks_core.
`default_nettype none

module matrix_keypad_scanner_8x8 (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output      logic                        in_stall,
    input  wire logic [mks_pkg::SENSE_W-1:0] sense_lines,
    output      logic                        out_valid,
    input  wire logic                        out_stall,
    output      logic [mks_pkg::COL_W-1:0]   drive_column,
    output      logic [mks_pkg::KEY_W-1:0]   key_code,
    output      logic                        scan_done,
    input  wire logic                        cfg_valid,
    output      logic                        cfg_ready,
    input  wire logic [mks_pkg::TICK_W-1:0]  cfg_data
);
    import mks_pkg::*;

    logic                 in_valid_reg;
    logic [SENSE_W-1:0]   sense_reg;
    logic                 out_valid_reg;
    mks_result_t          result_reg;
    logic [TICK_W-1:0]    debounce_reg;
    mks_result_t          core_result;
    logic                 out_free;
    logic                 step_en;

    assign out_free  = !out_valid_reg || !out_stall;
    assign step_en   = in_valid_reg && out_free;
    assign in_stall  = in_valid_reg && !out_free;
    assign cfg_ready = 1'b1;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            debounce_reg <= DEBOUNCE_RESET;
        end else if (cfg_valid) begin
            debounce_reg <= cfg_data;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (!in_stall) begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall) begin
            sense_reg <= sense_lines;
        end
    end

    // Scan update
    mks_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .step_en        (step_en),
        .sense          (sense_reg),
        .debounce_ticks (debounce_reg),
        .result         (core_result)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en) begin
            result_reg <= core_result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign drive_column = result_reg.drive_column;
    assign key_code     = result_reg.key_code;
    assign scan_done    = result_reg.scan_done;

endmodule

`default_nettype wire

/* rtl/mks_checker.sv */
// Port-level checks for the keypad scanner, bound to the top level.
// Depends on mks_pkg and matrix_keypad_scanner_8x8.
`default_nettype none

module mks_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        out_valid,
    input wire logic                        out_stall,
    input wire logic [mks_pkg::COL_W-1:0]   drive_column,
    input wire logic [mks_pkg::KEY_W-1:0]   key_code,
    input wire logic                        scan_done
);
    import mks_pkg::*;

    // A key code only comes with the end of a scan
    a_code_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (key_code != '0) |-> scan_done)
        else $error("key_code set without scan_done");

    // A finished scan restarts at column 0
    a_done_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && scan_done |-> (drive_column == '0))
        else $error("scan_done with nonzero drive_column");

    // Codes never exceed the top key
    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (key_code <= 7'd64))
        else $error("key_code out of range");

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(drive_column)
            && $stable(key_code) && $stable(scan_done))
        else $error("stalled result beat changed");

endmodule

bind matrix_keypad_scanner_8x8 mks_checker u_mks_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .drive_column (drive_column),
    .key_code     (key_code),
    .scan_done    (scan_done)
);

`default_nettype wire
